### hw/rtl/baa_pkg.sv
package baa_pkg;

   // Arena geometry.
   localparam int ARENA_BYTES  = 65536;
   localparam int HDR_BYTES    = 8;
   localparam int STORE_DEPTH  = ARENA_BYTES / HDR_BYTES;
   localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);

   // Field widths.
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 16;
   localparam int SIZE_W  = 16;
   localparam int ALIGN_W = 17;
   localparam int CAP_W   = 17;
   localparam int COUNT_W = 13;

   localparam logic [CAP_W-1:0]   CAP_MAX   = CAP_W'(ARENA_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Request opcodes.
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;
   localparam logic [OP_W-1:0] OP_RESET   = 2'd3;

   typedef struct packed {
      logic                   en;
      logic [STORE_IDX_W-1:0] idx;
      logic [SIZE_W-1:0]      data;
   } store_wr_type;

   typedef struct packed {
      logic                   en;
      logic [STORE_IDX_W-1:0] idx;
   } store_rd_type;

endpackage

### hw/rtl/baa_header_store.sv
// Header size store: one write port, one read port, read data registered.
module baa_header_store (
   input  logic                      clock,
   input  baa_pkg::store_wr_type     wr,
   input  baa_pkg::store_rd_type     rd,
   output logic [baa_pkg::SIZE_W-1:0] rd_data
);

   logic [baa_pkg::SIZE_W-1:0] header_mem [baa_pkg::STORE_DEPTH];
   logic [baa_pkg::SIZE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         header_mem[wr.idx] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= header_mem[rd.idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bump_arena_allocator.sv
// Bump-pointer arena allocator.
// Requests arrive on the req_ stream: req_tuser carries the opcode (allocate, free,
// reallocate, reset) and req_tdata the pointer, its null flag, the size and the
// alignment. Every request yields exactly one beat on the rsp_ stream with the user
// offset, a null flag, a copy order (source and length) for a reallocation that
// had to move, the ownership flag, the bytes in use and the live block count.
// A request passes an accept step in the idle state, an evaluation step that also
// accesses the header store, and a load step that fills the result register, which
// then drives the response beat. The load step waits for the registered read data
// of the header store, which has one write and one registered read port.
// The next request is accepted as soon as the result is loaded, so a result may
// wait in the output register while the following request is already in work; a
// stalled receiver holds the block at the load step of the request after that.
// Reset clears the bump offset, the last-block record and the live count, empties
// the output register and sets the capacity to the full arena. Header entries are
// not cleared. Capacity values above the arena size are clamped to the arena size.
// The user must write the capacity through csr_wr_en / csr_wr_data only while no
// request is in flight; the block itself does not enforce this.
module bump_arena_allocator (
   input  logic        clock,
   input  logic        reset,
   // Configuration: arena capacity.
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata, lowest bit up: addr[15:0], addr_null[16], req_size[32:17],
   // alignment[49:33], zero fill[55:50].
   input  logic [55:0] req_tdata,
   // tuser: op[1:0].
   input  logic [1:0]  req_tuser,
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata, lowest bit up: result_addr[15:0], result_null[16], copy_src[32:17],
   // copy_len[48:33], owned[49], used_bytes[66:50], live_count[79:67].
   output logic [79:0] rsp_tdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int AW = baa_pkg::ADDR_W;
   localparam int SW = baa_pkg::SIZE_W;
   localparam int CW = baa_pkg::CAP_W;
   localparam int NW = baa_pkg::COUNT_W;
   localparam int IW = baa_pkg::STORE_IDX_W;

   // Control state.
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cap_ff;
   logic [CW-1:0] bump_ff, bump_in;
   logic          last_valid_ff, last_valid_in;
   logic [AW-1:0] last_start_ff, last_start_in;
   logic [SW-1:0] last_size_ff, last_size_in;
   logic [NW-1:0] count_ff, count_in;
   logic          rsp_valid_ff;

   // Latched request.
   logic [1:0]              op_ff;
   logic [AW-1:0]           addr_ff;
   logic                    anull_ff;
   logic [SW-1:0]           size_ff;
   logic [baa_pkg::ALIGN_W-1:0] align_ff;

   // Pending result between evaluation and output load.
   logic          ok_ff, ok_in;
   logic [AW-1:0] res_ff, res_in;
   logic          copy_ff, copy_in;
   logic          owned_ff, owned_in;
   logic [SW-1:0] old_ff, old_in;
   logic          use_mem_ff, use_mem_in;

   logic [79:0]   rsp_data_ff;

   baa_pkg::store_wr_type wr;
   baa_pkg::store_rd_type rd;
   logic [SW-1:0]         rd_data;

   // Allocation arithmetic.
   logic [CW-1:0] align_m1, eff, eff_m1;
   logic          pow2_ok;
   logic [CW:0]   hdr_end;
   logic [CW:0]   desired;
   logic [CW+1:0] alloc_end;
   logic          alloc_ok;
   logic          take_alloc;
   logic          free_hit;
   logic [CW:0]   last_end;
   logic [NW-1:0] count_up, count_down;
   logic [CW-1:0] free_bump;
   logic [SW-1:0] old_val, copy_len;

   logic req_fire;
   logic rsp_free;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   baa_header_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // Effective alignment is at least the header size. The user offset is the
   // first aligned address past the header.
   always_comb begin
      align_m1  = align_ff - CW'(1);
      pow2_ok   = (align_ff != '0) && ((align_ff & align_m1) == '0);
      eff       = (align_ff < CW'(baa_pkg::HDR_BYTES)) ? CW'(baa_pkg::HDR_BYTES) : align_ff;
      eff_m1    = eff - CW'(1);
      hdr_end   = {1'b0, bump_ff} + (CW+1)'(baa_pkg::HDR_BYTES);
      desired   = (hdr_end + {1'b0, eff_m1}) & ~{1'b0, eff_m1};
      alloc_end = {1'b0, desired} + (CW+2)'(size_ff);
      alloc_ok  = (cap_ff != '0) && (size_ff != '0) && pow2_ok && (eff <= cap_ff)
                  && (hdr_end <= {1'b0, cap_ff})
                  && (alloc_end <= {2'b00, cap_ff});
      free_hit  = !anull_ff && last_valid_ff && (addr_ff == last_start_ff);
      last_end  = {1'b0, CW'(last_start_ff)} + (CW+1)'(size_ff);
      count_up  = (count_ff == baa_pkg::COUNT_MAX) ? count_ff : count_ff + NW'(1);
      count_down = (count_ff == '0) ? count_ff : count_ff - NW'(1);
      free_bump = (last_start_ff >= AW'(baa_pkg::HDR_BYTES))
                  ? CW'(last_start_ff) - CW'(baa_pkg::HDR_BYTES) : '0;
   end

   // Request evaluation; its results are committed in the evaluation cycle.
   always_comb begin
      bump_in       = bump_ff;
      last_valid_in = last_valid_ff;
      last_start_in = last_start_ff;
      last_size_in  = last_size_ff;
      count_in      = count_ff;
      owned_in      = !anull_ff && (cap_ff != '0) && ({1'b0, addr_ff} < cap_ff);
      ok_in         = 1'b0;
      res_in        = '0;
      copy_in       = 1'b0;
      old_in        = last_size_ff;
      use_mem_in    = 1'b0;
      take_alloc    = 1'b0;
      wr            = '0;
      rd            = '0;

      unique case (op_ff)
         baa_pkg::OP_ALLOC: begin
            take_alloc = 1'b1;
         end
         baa_pkg::OP_FREE: begin
            if (free_hit) begin
               bump_in       = free_bump;
               last_valid_in = 1'b0;
               last_start_in = '0;
               last_size_in  = '0;
               count_in      = count_down;
            end
         end
         baa_pkg::OP_REALLOC: begin
            if (anull_ff) begin
               take_alloc = 1'b1;
            end else if (size_ff == '0) begin
               if (free_hit) begin
                  bump_in       = free_bump;
                  last_valid_in = 1'b0;
                  last_start_in = '0;
                  last_size_in  = '0;
                  count_in      = count_down;
               end
            end else if (owned_in) begin
               if (!free_hit) begin
                  // Older block: its size is read from the header store while the
                  // new header is written; same entry forwards the new size.
                  take_alloc = 1'b1;
                  copy_in    = 1'b1;
                  rd.en      = alloc_ok;
                  rd.idx     = addr_ff[IW+2:3];
                  if (desired[IW+2:3] == addr_ff[IW+2:3]) begin
                     old_in = size_ff;
                  end else begin
                     use_mem_in = 1'b1;
                  end
               end else if (last_end <= {1'b0, cap_ff}) begin
                  // Last block resized in place.
                  wr.en        = 1'b1;
                  wr.idx       = last_start_ff[IW+2:3];
                  wr.data      = size_ff;
                  bump_in      = last_end[CW-1:0];
                  last_size_in = size_ff;
                  res_in       = addr_ff;
                  ok_in        = 1'b1;
               end else begin
                  take_alloc = 1'b1;
                  copy_in    = 1'b1;
               end
            end
         end
         baa_pkg::OP_RESET: begin
            bump_in       = '0;
            last_valid_in = 1'b0;
            last_start_in = '0;
            last_size_in  = '0;
            count_in      = '0;
         end
         default: begin
         end
      endcase

      if (take_alloc && alloc_ok) begin
         wr.en         = 1'b1;
         wr.idx        = desired[IW+2:3];
         wr.data       = size_ff;
         last_valid_in = 1'b1;
         last_start_in = desired[AW-1:0];
         last_size_in  = size_ff;
         bump_in       = alloc_end[CW-1:0];
         count_in      = count_up;
         res_in        = desired[AW-1:0];
         ok_in         = 1'b1;
      end
      if (!ok_in) begin
         copy_in = 1'b0;
      end
      if (state_ff != ST_CALC) begin
         wr.en = 1'b0;
         rd.en = 1'b0;
      end
   end

   always_comb begin
      old_val  = use_mem_ff ? rd_data : old_ff;
      copy_len = (old_val < size_ff) ? old_val : size_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= baa_pkg::CAP_MAX;
         bump_ff       <= '0;
         last_valid_ff <= 1'b0;
         last_start_ff <= '0;
         last_size_ff  <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cap_ff <= (csr_wr_data > baa_pkg::CAP_MAX) ? baa_pkg::CAP_MAX : csr_wr_data;
         end
         if (state_ff == ST_CALC) begin
            bump_ff       <= bump_in;
            last_valid_ff <= last_valid_in;
            last_start_ff <= last_start_in;
            last_size_ff  <= last_size_in;
            count_ff      <= count_in;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tuser;
         addr_ff  <= req_tdata[15:0];
         anull_ff <= req_tdata[16];
         size_ff  <= req_tdata[32:17];
         align_ff <= req_tdata[49:33];
      end
      if (state_ff == ST_CALC) begin
         ok_ff      <= ok_in;
         res_ff     <= res_in;
         copy_ff    <= copy_in;
         owned_ff   <= owned_in;
         old_ff     <= old_in;
         use_mem_ff <= use_mem_in;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= {count_ff,
                         bump_ff,
                         owned_ff,
                         copy_ff ? copy_len : SW'(0),
                         copy_ff ? addr_ff : AW'(0),
                         !ok_ff,
                         ok_ff ? res_ff : AW'(0)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
